// ----- hdl/sbe_pkg.sv -----
`timescale 1ns / 1ps
// Shared opcodes, status codes and cell controls for the stack bytecode executor.
package sbe_pkg;

	localparam int WordWidth = 64;

	typedef logic [WordWidth-1:0] word_t;
	typedef logic [2:0]           kind_t;
	typedef logic [1:0]           status_t;

	localparam kind_t KIND_PUSH  = 3'd0;
	localparam kind_t KIND_PRINT = 3'd1;
	localparam kind_t KIND_READ  = 3'd2;
	localparam kind_t KIND_ADD   = 3'd3;
	localparam kind_t KIND_STOP  = 3'd4;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_UNDERFLOW = 2'd1;
	localparam status_t ST_BAD_READ  = 2'd2;
	localparam status_t ST_FULL      = 2'd3;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_FROM_UP,
		CELL_FROM_DOWN
	} cell_op_t;

	// per-cycle control shared by the cell row: head cell and the rest
	typedef struct packed {
		cell_op_t head_op;
		cell_op_t body_op;
	} cell_ctrl_t;

endpackage

// ----- hdl/sbe_cell.sv -----
`timescale 1ns / 1ps
// One stack cell: holds an entry and loads from its upper or lower neighbor.
module sbe_cell (
	input  logic             clk,
	input  sbe_pkg::cell_op_t op,
	input  sbe_pkg::word_t   up_data,
	input  sbe_pkg::word_t   down_data,
	output sbe_pkg::word_t   data
);
	import sbe_pkg::*;

	word_t data_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_FROM_UP:   data_q <= up_data;
			CELL_FROM_DOWN: data_q <= down_data;
			default:        data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

// ----- hdl/stack_bytecode_executor.sv -----
`timescale 1ns / 1ps
// Top level of the stack bytecode executor: decode, stack count, cell row, result register.
//
//   channel | valid     | stall     | payload
//   input   | in_valid  | in_stall  | kind, immediate, read_value, read_ok
//   output  | out_valid | out_stall | print_valid, print_value, status, program_end
//
// One item per cycle while no held result stalls; the result is registered on acceptance.
// The stack is a row of cells with the top at cell 0; push shifts the row down,
// pop shifts it up, add writes the sum into cell 0 and shifts the rest up.
// Reset clears the stack count and the output valid; cell contents are left as is.
// A held result stalls the input side until it is taken.
module stack_bytecode_executor #(
	parameter int STACK_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  sbe_pkg::kind_t   kind,
	input  sbe_pkg::word_t   immediate,
	input  sbe_pkg::word_t   read_value,
	input  logic             read_ok,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             print_valid,
	output sbe_pkg::word_t   print_value,
	output sbe_pkg::status_t status,
	output logic             program_end
);
	import sbe_pkg::*;

	localparam int CntWidth = $clog2(STACK_DEPTH + 1);
	localparam logic [CntWidth-1:0] CntFull = CntWidth'(STACK_DEPTH);
	localparam logic [CntWidth-1:0] CntOne  = CntWidth'(1);

	logic [CntWidth-1:0] cnt_q, cnt_d;
	word_t               cell_data [STACK_DEPTH];
	word_t               head_value;
	cell_ctrl_t          ctrl;
	logic                accept;
	logic                empty, full, has_two;

	logic    out_valid_q;
	logic    print_valid_q;
	word_t   print_value_q;
	status_t status_q;
	logic    program_end_q;

	logic    res_pvalid;
	word_t   res_pvalue;
	status_t res_status;
	logic    res_end;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign empty    = (cnt_q == '0);
	assign full     = (cnt_q == CntFull);
	assign has_two  = (cnt_q > CntOne);

	always_comb begin
		ctrl       = '{head_op: CELL_HOLD, body_op: CELL_HOLD};
		head_value = immediate;
		cnt_d      = cnt_q;
		res_pvalid = 1'b0;
		res_pvalue = '0;
		res_status = ST_OK;
		res_end    = 1'b0;
		case (kind)
			KIND_PUSH: begin
				if (full) begin
					res_status = ST_FULL;
				end else begin
					ctrl  = '{head_op: CELL_FROM_UP, body_op: CELL_FROM_UP};
					cnt_d = cnt_q + CntOne;
				end
			end
			KIND_PRINT: begin
				if (empty) begin
					res_status = ST_UNDERFLOW;
				end else begin
					ctrl       = '{head_op: CELL_FROM_DOWN, body_op: CELL_FROM_DOWN};
					cnt_d      = cnt_q - CntOne;
					res_pvalid = 1'b1;
					res_pvalue = cell_data[0];
				end
			end
			KIND_READ: begin
				head_value = read_value;
				if (!read_ok) begin
					res_status = ST_BAD_READ;
				end else if (full) begin
					res_status = ST_FULL;
				end else begin
					ctrl  = '{head_op: CELL_FROM_UP, body_op: CELL_FROM_UP};
					cnt_d = cnt_q + CntOne;
				end
			end
			KIND_ADD: begin
				head_value = cell_data[0] + cell_data[1];
				if (has_two) begin
					// two pops and a push: net one pop, sum lands on top
					ctrl  = '{head_op: CELL_FROM_UP, body_op: CELL_FROM_DOWN};
					cnt_d = cnt_q - CntOne;
				end else begin
					// drop the lone entry, if any
					res_status = ST_UNDERFLOW;
					cnt_d      = '0;
				end
			end
			KIND_STOP: begin
				cnt_d   = '0;
				res_end = 1'b1;
			end
			default: begin
			end
		endcase
		if (!accept) begin
			ctrl  = '{head_op: CELL_HOLD, body_op: CELL_HOLD};
			cnt_d = cnt_q;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
			word_t up_w, down_w;
			if (gi == 0) begin : g_head
				assign up_w = head_value;
			end else begin : g_body_up
				assign up_w = cell_data[gi-1];
			end
			if (gi == STACK_DEPTH - 1) begin : g_tail
				assign down_w = cell_data[gi];
			end else begin : g_body_down
				assign down_w = cell_data[gi+1];
			end
			sbe_cell u_cell (
				.clk      (clk),
				.op       ((gi == 0) ? ctrl.head_op : ctrl.body_op),
				.up_data  (up_w),
				.down_data(down_w),
				.data     (cell_data[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			print_valid_q <= res_pvalid;
			print_value_q <= res_pvalue;
			status_q      <= res_status;
			program_end_q <= res_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign print_valid = print_valid_q;
	assign print_value = print_value_q;
	assign status      = status_q;
	assign program_end = program_end_q;

endmodule

// ----- hdl/sbe_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the stack bytecode executor, bound to the top level.
module sbe_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input sbe_pkg::kind_t   kind,
	input logic             out_valid,
	input logic             out_stall,
	input logic             print_valid,
	input sbe_pkg::word_t   print_value,
	input sbe_pkg::status_t status,
	input logic             program_end
);
	import sbe_pkg::*;

	// stop item shows up as program end on the next cycle
	a_stop_ends: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && kind == KIND_STOP |=> out_valid && program_end)
		else $error("stop item did not report program end");

	a_print_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && print_valid |-> status == ST_OK && !program_end)
		else $error("printed value with bad status or program end");

	a_print_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !print_valid |-> print_value == '0)
		else $error("print value not zero without print");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(print_value) && $stable(status))
		else $error("stalled result changed");

endmodule

bind stack_bytecode_executor sbe_checker u_sbe_checker (.*);
